/* rtl/core/plt_pkg.sv */
// Shared types and constants for the positional list table.
// Used by the request/result interfaces, the controller, the datapath and the top level.
package plt_pkg;

  localparam int unsigned CAPACITY_DEF = 64;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned POS_W        = 7;
  localparam int unsigned LEN_W        = 7;
  localparam int unsigned KIND_W       = 2;
  localparam int unsigned STATUS_W     = 2;

  // Request kinds
  localparam logic [KIND_W-1:0] KIND_INSERT   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DELETE   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RETRIEVE = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

  // Controller to datapath commands
  typedef struct packed {
    logic req_load;  // capture the request on a transfer
    logic eval;      // latch status, data default and start index
    logic rd_en;     // issue a RAM read
    logic wr_en;     // write the RAM at the working index
    logic wr_item;   // write data is the request item, else read data
    logic idx_inc;
    logic idx_dec;
    logic cnt_inc;
    logic cnt_dec;
    logic data_cap;  // capture RAM read data as result data
    logic res_load;  // move result into the output register
  } plt_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              ok;        // request is a valid, error-free list operation
    logic              ins_done;  // insert gap has reached the target slot
    logic              del_done;  // delete shift has reached the list tail
    logic              out_free;  // output register can take a result
  } plt_sts_t;

endpackage

/* rtl/core/plt_req_if.sv */
// Request channel of the positional list table: valid/ready plus request payload.
// Depends on plt_pkg for field widths.
interface plt_req_if;
  logic                              valid;
  logic                              ready;
  logic [plt_pkg::KIND_W-1:0]        kind;
  logic [plt_pkg::POS_W-1:0]         position;
  logic signed [plt_pkg::DATA_W-1:0] item;

  modport source (output valid, output kind, output position, output item, input ready);
  modport sink   (input valid, input kind, input position, input item, output ready);
endinterface

/* rtl/core/plt_rsp_if.sv */
// Result channel of the positional list table: valid/ready plus result payload.
// Depends on plt_pkg for field widths.
interface plt_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [plt_pkg::STATUS_W-1:0]      status;
  logic signed [plt_pkg::DATA_W-1:0] data;
  logic [plt_pkg::LEN_W-1:0]         length;
  logic                              empty_res;

  modport source (output valid, output status, output data, output length,
                  output empty_res, input ready);
  modport sink   (input valid, input status, input data, input length,
                  input empty_res, output ready);
endinterface

/* rtl/core/plt_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module plt_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/plt_ctrl.sv */
// Controller of the positional list table: sequences evaluation, element moves and result hand-off.
// Depends on plt_pkg for command/status structs and kind codes.
module plt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  plt_pkg::plt_sts_t sts_i,
  output plt_pkg::plt_cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EVAL   = 3'd1;
  localparam logic [2:0] S_INS_RD = 3'd2;
  localparam logic [2:0] S_INS_WR = 3'd3;
  localparam logic [2:0] S_DEL_RD = 3'd4;
  localparam logic [2:0] S_DEL_WR = 3'd5;
  localparam logic [2:0] S_GET    = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.req_load = 1'b1;
          state_d        = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        if (!sts_i.ok) begin
          state_d = S_DONE;
        end else begin
          case (sts_i.kind)
            plt_pkg::KIND_INSERT: state_d = S_INS_RD;
            plt_pkg::KIND_DELETE: state_d = S_DEL_RD;
            plt_pkg::KIND_RETRIEVE: begin
              cmd_o.rd_en = 1'b1;
              state_d     = S_GET;
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      // Open the gap from the tail backward, then drop the item in
      S_INS_RD: begin
        if (sts_i.ins_done) begin
          cmd_o.wr_en   = 1'b1;
          cmd_o.wr_item = 1'b1;
          cmd_o.cnt_inc = 1'b1;
          state_d       = S_DONE;
        end else begin
          cmd_o.rd_en = 1'b1;
          state_d     = S_INS_WR;
        end
      end
      S_INS_WR: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.idx_dec = 1'b1;
        state_d       = S_INS_RD;
      end
      // Close the gap from the deleted slot toward the tail
      S_DEL_RD: begin
        if (sts_i.del_done) begin
          cmd_o.cnt_dec = 1'b1;
          state_d       = S_DONE;
        end else begin
          cmd_o.rd_en = 1'b1;
          state_d     = S_DEL_WR;
        end
      end
      S_DEL_WR: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.idx_inc = 1'b1;
        state_d       = S_DEL_RD;
      end
      S_GET: begin
        cmd_o.data_cap = 1'b1;
        state_d        = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.res_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

/* rtl/core/plt_dp.sv */
// Datapath of the positional list table: request and count registers, element RAM, result register.
// Depends on plt_pkg and plt_ram.
module plt_dp #(
  parameter int unsigned CAPACITY = plt_pkg::CAPACITY_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  plt_pkg::plt_cmd_t                 cmd_i,
  output plt_pkg::plt_sts_t                 sts_o,
  input  logic [plt_pkg::KIND_W-1:0]        kind_i,
  input  logic [plt_pkg::POS_W-1:0]         position_i,
  input  logic signed [plt_pkg::DATA_W-1:0] item_i,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic [plt_pkg::STATUS_W-1:0]      status_o,
  output logic signed [plt_pkg::DATA_W-1:0] data_o,
  output logic [plt_pkg::LEN_W-1:0]         length_o,
  output logic                              empty_res_o
);

  localparam int unsigned AW    = $clog2(CAPACITY);
  localparam int unsigned CW    = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W = ((CW > plt_pkg::POS_W) ? CW : plt_pkg::POS_W) + 1;

  // Request register
  logic [plt_pkg::KIND_W-1:0] kind_q;
  logic [plt_pkg::POS_W-1:0]  pos_q;
  logic [plt_pkg::DATA_W-1:0] item_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.req_load) begin
      kind_q <= kind_i;
      pos_q  <= position_i;
      item_q <= item_i;
    end
  end

  // Item count
  logic [CW-1:0] count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.cnt_inc) begin
      count_q <= count_q + CW'(1);
    end else if (cmd_i.cnt_dec) begin
      count_q <= count_q - CW'(1);
    end
  end

  // Request checks against the current length
  logic [CMP_W-1:0]             pos_w, cnt_w;
  logic [plt_pkg::STATUS_W-1:0] status_d;
  logic                         kind_valid;

  assign pos_w = CMP_W'(pos_q);
  assign cnt_w = CMP_W'(count_q);

  always_comb begin
    status_d   = plt_pkg::ST_OK;
    kind_valid = 1'b1;
    case (kind_q)
      plt_pkg::KIND_INSERT: begin
        if (pos_q == '0 || pos_w > cnt_w + CMP_W'(1)) begin
          status_d = plt_pkg::ST_RANGE;
        end else if (count_q == CW'(CAPACITY)) begin
          status_d = plt_pkg::ST_FULL;
        end
      end
      plt_pkg::KIND_DELETE, plt_pkg::KIND_RETRIEVE: begin
        if (count_q == '0) begin
          status_d = plt_pkg::ST_EMPTY;
        end else if (pos_q == '0 || pos_w > cnt_w) begin
          status_d = plt_pkg::ST_RANGE;
        end
      end
      default: kind_valid = 1'b0;
    endcase
  end

  // Working index: write address of the next move
  logic [AW-1:0] idx_q;
  logic [AW-1:0] pos_idx;

  assign pos_idx = AW'(pos_q) - AW'(1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval) begin
      idx_q <= (kind_q == plt_pkg::KIND_INSERT) ? AW'(count_q) : pos_idx;
    end else if (cmd_i.idx_dec) begin
      idx_q <= idx_q - AW'(1);
    end else if (cmd_i.idx_inc) begin
      idx_q <= idx_q + AW'(1);
    end
  end

  // Element store
  logic [AW-1:0]              rd_addr;
  logic [plt_pkg::DATA_W-1:0] rdata;

  always_comb begin
    case (kind_q)
      plt_pkg::KIND_INSERT: rd_addr = idx_q - AW'(1);
      plt_pkg::KIND_DELETE: rd_addr = idx_q + AW'(1);
      default:              rd_addr = pos_idx;
    endcase
  end

  plt_ram #(
    .Width (plt_pkg::DATA_W),
    .Depth (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_en),
    .waddr_i (idx_q),
    .wdata_i (cmd_i.wr_item ? item_q : rdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rdata)
  );

  // Working result
  logic [plt_pkg::STATUS_W-1:0] st_q;
  logic [plt_pkg::DATA_W-1:0]   data_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval) begin
      st_q   <= status_d;
      data_q <= (kind_q == plt_pkg::KIND_RETRIEVE && status_d != plt_pkg::ST_OK) ?
                '1 : '0;
    end else if (cmd_i.data_cap) begin
      data_q <= rdata;
    end
  end

  // Output register
  logic                         rsp_valid_q;
  logic [plt_pkg::STATUS_W-1:0] rsp_status_q;
  logic [plt_pkg::DATA_W-1:0]   rsp_data_q;
  logic [plt_pkg::LEN_W-1:0]    rsp_length_q;
  logic                         rsp_empty_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (cmd_i.res_load) begin
      rsp_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      rsp_status_q <= st_q;
      rsp_data_q   <= data_q;
      rsp_length_q <= plt_pkg::LEN_W'(count_q);
      rsp_empty_q  <= (count_q == '0);
    end
  end

  assign out_valid_o = rsp_valid_q;
  assign status_o    = rsp_status_q;
  assign data_o      = rsp_data_q;
  assign length_o    = rsp_length_q;
  assign empty_res_o = rsp_empty_q;

  // Status to controller
  assign sts_o.kind     = kind_q;
  assign sts_o.ok       = kind_valid && (status_d == plt_pkg::ST_OK);
  assign sts_o.ins_done = (idx_q == pos_idx);
  assign sts_o.del_done = (CW'(idx_q) + CW'(1)) >= count_q;
  assign sts_o.out_free = !rsp_valid_q || out_ready_i;

  // Checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("item count above capacity");

  a_inc_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cnt_inc |-> count_q != CW'(CAPACITY))
    else $error("insert committed on a full list");

  a_dec_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cnt_dec |-> count_q != '0)
    else $error("delete committed on an empty list");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.res_load |-> (!rsp_valid_q || out_ready_i))
    else $error("result overwrote an untaken result");

endmodule

/* rtl/core/positional_list_table.sv */
// Positional list table: one request in, one result out per transfer.
// Each request is evaluated first; an error or an unused kind then goes straight to the result,
// a retrieve reads one element, an insert shifts elements p..length up, a delete those after p down.
// One request at a time: the next request is taken only once the result is in the output register,
// which waits while the previous result is untaken; each element move is a RAM read then a write.
// Reset clears the item count and output valid; the element RAM is not cleared.
module positional_list_table #(
  parameter int unsigned CAPACITY = plt_pkg::CAPACITY_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  plt_req_if.sink   req_i,
  plt_rsp_if.source rsp_o
);

  plt_pkg::plt_cmd_t cmd;
  plt_pkg::plt_sts_t sts;

  plt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  plt_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .kind_i      (req_i.kind),
    .position_i  (req_i.position),
    .item_i      (req_i.item),
    .out_ready_i (rsp_o.ready),
    .out_valid_o (rsp_o.valid),
    .status_o    (rsp_o.status),
    .data_o      (rsp_o.data),
    .length_o    (rsp_o.length),
    .empty_res_o (rsp_o.empty_res)
  );

endmodule

/* tb/sv/positional_list_table_checker.sv */
// Scoreboard for the positional list table: watches both channels, predicts each result.
// Depends on plt_pkg and on the plt_req_if / plt_rsp_if interfaces.
module positional_list_table_checker #(
  parameter int unsigned CAPACITY = plt_pkg::CAPACITY_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  plt_req_if   req_mon,
  plt_rsp_if   rsp_mon,
  output int   fail_cnt_o,
  output int   pending_o,
  output int   checked_o,
  output int   peak_len_o,
  output int   full_hits_o
);

  localparam int REPORT_MAX = 10;

  typedef struct packed {
    logic [plt_pkg::STATUS_W-1:0]      status;
    logic signed [plt_pkg::DATA_W-1:0] data;
    logic [plt_pkg::LEN_W-1:0]         length;
    logic                              empty_res;
  } list_result_t;

  // predicted list contents, head at index 0
  logic signed [plt_pkg::DATA_W-1:0] list_q[$];
  list_result_t                      result_q[$];
  list_result_t                      got;
  list_result_t                      want;
  int                                fails;
  int                                checked;
  int                                peak_len;
  int                                full_hits;

  // Apply one request to the predicted list and return its result.
  function automatic list_result_t apply_request(
      input logic [plt_pkg::KIND_W-1:0]        kind,
      input logic [plt_pkg::POS_W-1:0]         pos,
      input logic signed [plt_pkg::DATA_W-1:0] item);
    list_result_t res;
    int           cnt;
    int           p;
    res = '0;
    cnt = list_q.size();
    p   = int'(pos);
    case (kind)
      plt_pkg::KIND_INSERT: begin
        if (p < 1 || p > cnt + 1) begin
          res.status = plt_pkg::ST_RANGE;
        end else if (cnt >= int'(CAPACITY)) begin
          res.status = plt_pkg::ST_FULL;
        end else begin
          list_q.insert(p - 1, item);
        end
      end
      plt_pkg::KIND_DELETE: begin
        if (cnt == 0) begin
          res.status = plt_pkg::ST_EMPTY;
        end else if (p < 1 || p > cnt) begin
          res.status = plt_pkg::ST_RANGE;
        end else begin
          list_q.delete(p - 1);
        end
      end
      plt_pkg::KIND_RETRIEVE: begin
        if (cnt == 0) begin
          res.status = plt_pkg::ST_EMPTY;
          res.data   = -1;
        end else if (p < 1 || p > cnt) begin
          res.status = plt_pkg::ST_RANGE;
          res.data   = -1;
        end else begin
          res.data = list_q[p-1];
        end
      end
      default: ;  // unused kind: no change, ok status
    endcase
    res.length    = plt_pkg::LEN_W'(list_q.size());
    res.empty_res = (list_q.size() == 0);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      list_q.delete();
      result_q.delete();
      fails     = 0;
      checked   = 0;
      peak_len  = 0;
      full_hits = 0;
    end else begin
      // result side: compare against the oldest prediction
      if (rsp_mon.valid && rsp_mon.ready) begin
        got = '{rsp_mon.status, rsp_mon.data, rsp_mon.length, rsp_mon.empty_res};
        if (result_q.size() == 0) begin
          fails++;
          if (fails <= REPORT_MAX)
            $display("[%0t] unexpected result: status=%0d data=%0d length=%0d empty=%0b",
                     $realtime, got.status, got.data, got.length, got.empty_res);
        end else begin
          want = result_q.pop_front();
          checked++;
          if (got !== want) begin
            fails++;
            if (fails <= REPORT_MAX)
              $display({"[%0t] result mismatch: exp status=%0d data=%0d length=%0d empty=%0b",
                        " / got status=%0d data=%0d length=%0d empty=%0b"},
                       $realtime, want.status, want.data, want.length, want.empty_res,
                       got.status, got.data, got.length, got.empty_res);
          end
        end
      end
      // request side: predict the result of each transfer
      if (req_mon.valid && req_mon.ready) begin
        want = apply_request(req_mon.kind, req_mon.position, req_mon.item);
        result_q.push_back(want);
        if (want.status == plt_pkg::ST_FULL) full_hits++;
        if (list_q.size() > peak_len) peak_len = list_q.size();
      end
    end
    fail_cnt_o  <= fails;
    pending_o   <= result_q.size();
    checked_o   <= checked;
    peak_len_o  <= peak_len;
    full_hits_o <= full_hits;
  end

endmodule

/* tb/sv/positional_list_table_tb.sv */
// Testbench top for positional_list_table: clock, reset, request and result traffic, verdict.
// Depends on plt_pkg, the channel interfaces, the DUT and positional_list_table_checker.
module positional_list_table_tb;

  localparam int CLK_PERIOD   = 12;
  localparam int RESET_CYCLES = 12;
  localparam int N_ITEMS      = 1500;
  localparam int MAX_GAP      = 12;
  localparam int LONG_HOLD    = 500;
  localparam int TAIL_CYCLES  = 160;  // above the slowest insert, at the head of a list one short of capacity
  localparam int LIMIT_CYCLES = 2_000_000;
  localparam int CAP          = plt_pkg::CAPACITY_DEF;

  localparam logic [plt_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

  typedef enum int {EP_GROW, EP_SHRINK, EP_MIX, EP_FILL, EP_DRAIN} episode_e;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  plt_req_if req_ch();
  plt_rsp_if rsp_ch();

  int fail_cnt;
  int pending;
  int checked;
  int peak_len;
  int full_hits;

  int list_len;       // list length as seen by the request stream
  int n_sent;
  int kind_cnt[4];
  bit tx_burst;
  bit rx_burst;
  int rx_hold_cycles;

  logic [plt_pkg::KIND_W-1:0] op_kinds[3] = '{plt_pkg::KIND_INSERT, plt_pkg::KIND_DELETE,
                                              plt_pkg::KIND_RETRIEVE};

  positional_list_table u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch)
  );

  positional_list_table_checker #(.CAPACITY(CAP)) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_mon     (req_ch),
    .rsp_mon     (rsp_ch),
    .fail_cnt_o  (fail_cnt),
    .pending_o   (pending),
    .checked_o   (checked),
    .peak_len_o  (peak_len),
    .full_hits_o (full_hits)
  );

  always begin
    #(CLK_PERIOD/2) clk_i = 1'b1;
    #(CLK_PERIOD/2) clk_i = 1'b0;
  end

  // Run limit
  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("Timeout with %0d results outstanding", pending);
    $display("Test completed with failures");
    $finish;
  end

  // Result side: random stalls, calm stretches, and one long hold-off on request
  initial begin
    int stall;
    int hold;
    rsp_ch.ready = 1'b0;
    rx_burst     = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      hold = rx_hold_cycles;
      if (hold > 0) begin
        rx_hold_cycles = 0;
        rsp_ch.ready <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
      stall = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!(rsp_ch.valid && rsp_ch.ready));
    end
  end

  // Offer one request and hold it until the transfer
  task automatic send_req(input logic [plt_pkg::KIND_W-1:0]        kind,
                          input int                                pos,
                          input logic signed [plt_pkg::DATA_W-1:0] item);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_ch.valid    <= 1'b1;
    req_ch.kind     <= kind;
    req_ch.position <= plt_pkg::POS_W'(pos);
    req_ch.item     <= item;
    do @(posedge clk_i); while (!req_ch.ready);
    // keep track of the length so positions can be aimed in range
    if (kind == plt_pkg::KIND_INSERT && pos >= 1 && pos <= list_len + 1 && list_len < CAP)
      list_len++;
    else if (kind == plt_pkg::KIND_DELETE && list_len > 0 && pos >= 1 && pos <= list_len)
      list_len--;
    kind_cnt[kind]++;
    if (kind != KIND_UNUSED) n_sent++;
  endtask

  // Stop offering until every outstanding result has come back
  task automatic drain_results();
    req_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Valid position for an op at the current length; on an empty list a delete or retrieve gets 0 to 2
  function automatic int in_range_pos(input logic [plt_pkg::KIND_W-1:0] kind);
    if (kind == plt_pkg::KIND_INSERT) return $urandom_range(1, list_len + 1);
    if (list_len == 0) return $urandom_range(0, 2);
    return $urandom_range(1, list_len);
  endfunction

  // One request shaped by the episode: mostly well-formed, some edges and noise
  task automatic random_request(input episode_e mode);
    int                         roll;
    int                         pick;
    int                         pos;
    logic [plt_pkg::KIND_W-1:0] kind;
    roll = $urandom_range(0, 99);
    if (roll < 4) begin
      kind = KIND_UNUSED;
      pos  = $urandom_range(0, 127);
    end else if (roll < 12) begin
      kind = op_kinds[$urandom_range(0, 2)];
      pos  = $urandom_range(0, 127);
    end else if (roll < 20) begin
      // just inside and just outside the valid window
      kind = op_kinds[$urandom_range(0, 2)];
      case ($urandom_range(0, 3))
        0:       pos = 0;
        1:       pos = list_len;
        2:       pos = list_len + 1;
        default: pos = list_len + 2;
      endcase
    end else begin
      pick = $urandom_range(0, 99);
      case (mode)
        EP_GROW:   kind = (pick < 75) ? plt_pkg::KIND_INSERT :
                          (pick < 85) ? plt_pkg::KIND_DELETE : plt_pkg::KIND_RETRIEVE;
        EP_SHRINK: kind = (pick < 10) ? plt_pkg::KIND_INSERT :
                          (pick < 85) ? plt_pkg::KIND_DELETE : plt_pkg::KIND_RETRIEVE;
        default:   kind = (pick < 35) ? plt_pkg::KIND_INSERT :
                          (pick < 65) ? plt_pkg::KIND_DELETE : plt_pkg::KIND_RETRIEVE;
      endcase
      pos = in_range_pos(kind);
    end
    send_req(kind, pos, $urandom());
  endtask

  // Stimulus and verdict
  initial begin
    int       ep;
    int       n;
    episode_e mode;
    req_ch.valid    = 1'b0;
    req_ch.kind     = plt_pkg::KIND_INSERT;
    req_ch.position = '0;
    req_ch.item     = '0;
    rx_hold_cycles  = 0;
    tx_burst        = 1'b0;
    list_len        = 0;
    n_sent          = 0;
    kind_cnt        = '{default: 0};
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty list, extremes of the item, head/middle/tail, range edges
    send_req(plt_pkg::KIND_RETRIEVE, 1, 0);
    send_req(plt_pkg::KIND_DELETE, 0, 0);
    send_req(plt_pkg::KIND_INSERT, 0, 5);
    send_req(plt_pkg::KIND_INSERT, 2, 5);
    send_req(KIND_UNUSED, 127, -1);
    send_req(plt_pkg::KIND_INSERT, 1, 32'sh7fff_ffff);
    send_req(plt_pkg::KIND_INSERT, 1, 32'sh8000_0000);
    send_req(plt_pkg::KIND_INSERT, 3, -1);
    send_req(plt_pkg::KIND_INSERT, 2, 0);
    send_req(plt_pkg::KIND_INSERT, 6, 7);
    send_req(plt_pkg::KIND_RETRIEVE, 1, 0);
    send_req(plt_pkg::KIND_RETRIEVE, 4, 0);
    send_req(plt_pkg::KIND_RETRIEVE, 0, 0);
    send_req(plt_pkg::KIND_RETRIEVE, 5, 0);
    send_req(plt_pkg::KIND_RETRIEVE, 127, 0);
    send_req(plt_pkg::KIND_DELETE, 5, 0);
    send_req(plt_pkg::KIND_DELETE, 0, 0);
    send_req(plt_pkg::KIND_DELETE, 2, 0);
    send_req(plt_pkg::KIND_DELETE, 3, 0);
    send_req(plt_pkg::KIND_DELETE, 1, 0);
    send_req(plt_pkg::KIND_INSERT, 2, 32'sh5555_5555);
    send_req(plt_pkg::KIND_RETRIEVE, 2, 0);
    send_req(KIND_UNUSED, 0, 0);
    send_req(plt_pkg::KIND_DELETE, 1, 0);
    send_req(plt_pkg::KIND_DELETE, 1, 0);
    drain_results();

    // random episodes
    ep = 0;
    while (n_sent < N_ITEMS) begin
      mode     = episode_e'($urandom_range(0, 4));
      tx_burst = ($urandom_range(0, 3) == 0);
      if (ep == 2) mode = EP_FILL;
      if (ep == 4) mode = EP_DRAIN;
      if (ep == 6) begin
        // receiver goes quiet while requests keep coming
        tx_burst       = 1'b1;
        rx_hold_cycles = LONG_HOLD;
      end
      if (ep % 9 == 3) drain_results();
      case (mode)
        EP_FILL: begin
          while (list_len < CAP)
            send_req(plt_pkg::KIND_INSERT, in_range_pos(plt_pkg::KIND_INSERT), $urandom());
          repeat (4) send_req(plt_pkg::KIND_INSERT, $urandom_range(0, CAP + 3), $urandom());
          send_req(plt_pkg::KIND_RETRIEVE, CAP, 0);
          send_req(plt_pkg::KIND_RETRIEVE, CAP + 1, 0);
        end
        EP_DRAIN: begin
          while (list_len > 0)
            send_req(plt_pkg::KIND_DELETE, in_range_pos(plt_pkg::KIND_DELETE), $urandom());
          repeat (4) random_request(EP_MIX);
        end
        default: begin
          n = $urandom_range(10, 40);
          repeat (n) random_request(mode);
        end
      endcase
      ep++;
    end

    // wind down
    req_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Sent %0d inserts, %0d deletes, %0d retrieves, %0d unused-kind requests",
             kind_cnt[plt_pkg::KIND_INSERT], kind_cnt[plt_pkg::KIND_DELETE],
             kind_cnt[plt_pkg::KIND_RETRIEVE], kind_cnt[KIND_UNUSED]);
    $display("Checked %0d results; list peaked at %0d entries, %0d inserts refused as full",
             checked, peak_len, full_hits);
    if (fail_cnt == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
